@@ rtl/mi3_pkg.sv @@
`timescale 1ns / 1ps

package mi3_pkg;

	// element format defaults
	localparam int ELEM_WIDTH  = 32;
	localparam int FRAC_BITS   = 16;
	localparam int FIELD_WIDTH = 32;

	// singularity threshold register
	localparam int THR_WIDTH = 62;
	localparam logic [THR_WIDTH-1:0] THR_RESET = 62'd281474977;

	// entries between front and back
	localparam int QUEUE_DEPTH = 16;

	// transposed cofactor k = m[P]*m[Q] - m[R]*m[S], elements numbered row major
	localparam int CF_P [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int CF_Q [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int CF_R [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int CF_S [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	// cofactors used for the row 0 expansion of the determinant
	localparam int DET_ADJ [3] = '{0, 3, 6};

	typedef struct packed {
		logic signed [FIELD_WIDTH-1:0] m_r0c0;
		logic signed [FIELD_WIDTH-1:0] m_r0c1;
		logic signed [FIELD_WIDTH-1:0] m_r0c2;
		logic signed [FIELD_WIDTH-1:0] m_r1c0;
		logic signed [FIELD_WIDTH-1:0] m_r1c1;
		logic signed [FIELD_WIDTH-1:0] m_r1c2;
		logic signed [FIELD_WIDTH-1:0] m_r2c0;
		logic signed [FIELD_WIDTH-1:0] m_r2c1;
		logic signed [FIELD_WIDTH-1:0] m_r2c2;
	} mi3_in_t;

	typedef struct packed {
		logic signed [FIELD_WIDTH-1:0] inv_r0c0;
		logic signed [FIELD_WIDTH-1:0] inv_r0c1;
		logic signed [FIELD_WIDTH-1:0] inv_r0c2;
		logic signed [FIELD_WIDTH-1:0] inv_r1c0;
		logic signed [FIELD_WIDTH-1:0] inv_r1c1;
		logic signed [FIELD_WIDTH-1:0] inv_r1c2;
		logic signed [FIELD_WIDTH-1:0] inv_r2c0;
		logic signed [FIELD_WIDTH-1:0] inv_r2c1;
		logic signed [FIELD_WIDTH-1:0] inv_r2c2;
		logic signed [FIELD_WIDTH-1:0] determinant;
		logic                          invertible;
	} mi3_out_t;

endpackage

@@ rtl/mi3_queue.sv @@
`timescale 1ns / 1ps

module mi3_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mi3_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             full;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");

endmodule

@@ rtl/mi3_front.sv @@
`timescale 1ns / 1ps

module mi3_front #(
	parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mi3_pkg::mi3_in_t  in_data,
	input  logic              pop,
	output logic              push,
	output logic [9*2*ELEM_WIDTH+3*ELEM_WIDTH+2:0] push_data
);

	localparam int EW = ELEM_WIDTH;
	localparam int CW = 2 * EW;
	localparam int DW = 3 * EW + 2;
	localparam int QD = mi3_pkg::QUEUE_DEPTH;
	localparam int OW = $clog2(QD + 1);

	logic [OW-1:0] occ_q;
	logic          acc;
	logic [31:0]   raw [9];

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [EW-1:0] elem_s1 [9];
	logic signed [CW-1:0] prod_s2 [18];
	logic signed [EW-1:0] abc_s2 [3];
	logic signed [CW-1:0] adj_s3 [9];
	logic signed [EW-1:0] abc_s3 [3];
	logic signed [CW:0]   plo_s4 [3];
	logic signed [CW-1:0] phi_s4 [3];
	logic signed [CW-1:0] adj_s4 [9];
	logic signed [DW-1:0] pt_s5 [3];
	logic signed [CW-1:0] adj_s5 [9];
	logic signed [DW-1:0] det_s6;
	logic signed [CW-1:0] adj_s6 [9];
	logic [DW-1:0]        dmag_s7;
	logic                 dneg_s7;
	logic signed [CW-1:0] adj_s7 [9];

	// items in flight plus items queued never exceed the queue depth
	assign in_stall = (occ_q >= OW'(QD));
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({acc, pop})
				2'b10:   occ_q <= occ_q + OW'(1);
				2'b01:   occ_q <= occ_q - OW'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	assign raw[0] = in_data.m_r0c0;
	assign raw[1] = in_data.m_r0c1;
	assign raw[2] = in_data.m_r0c2;
	assign raw[3] = in_data.m_r1c0;
	assign raw[4] = in_data.m_r1c1;
	assign raw[5] = in_data.m_r1c2;
	assign raw[6] = in_data.m_r2c0;
	assign raw[7] = in_data.m_r2c1;
	assign raw[8] = in_data.m_r2c2;

	// datapath stages
	always_ff @(posedge clk) begin
		// element capture
		for (int k = 0; k < 9; k++) begin
			elem_s1[k] <= signed'(raw[k][EW-1:0]);
		end
		// cofactor products
		for (int k = 0; k < 9; k++) begin
			prod_s2[2*k]   <= elem_s1[mi3_pkg::CF_P[k]] * elem_s1[mi3_pkg::CF_Q[k]];
			prod_s2[2*k+1] <= elem_s1[mi3_pkg::CF_R[k]] * elem_s1[mi3_pkg::CF_S[k]];
		end
		for (int t = 0; t < 3; t++) begin
			abc_s2[t] <= elem_s1[t];
		end
		// cofactors
		for (int k = 0; k < 9; k++) begin
			adj_s3[k] <= prod_s2[2*k] - prod_s2[2*k+1];
		end
		abc_s3 <= abc_s2;
		// row 0 expansion, cofactor split into low and high halves
		for (int t = 0; t < 3; t++) begin
			plo_s4[t] <= abc_s3[t] *
				$signed({1'b0, adj_s3[mi3_pkg::DET_ADJ[t]][EW-1:0]});
			phi_s4[t] <= abc_s3[t] * $signed(adj_s3[mi3_pkg::DET_ADJ[t]][CW-1:EW]);
		end
		adj_s4 <= adj_s3;
		// recombine halves
		for (int t = 0; t < 3; t++) begin
			pt_s5[t] <= (DW'(phi_s4[t]) <<< EW) + DW'(plo_s4[t]);
		end
		adj_s5 <= adj_s4;
		// determinant
		det_s6 <= pt_s5[0] + pt_s5[1] + pt_s5[2];
		adj_s6 <= adj_s5;
		// sign and magnitude
		dneg_s7 <= det_s6[DW-1];
		dmag_s7 <= det_s6[DW-1] ? DW'(-det_s6) : DW'(det_s6);
		adj_s7  <= adj_s6;
	end

	// queue entry: cofactors, determinant magnitude, determinant sign
	assign push = vld_s7;
	always_comb begin
		push_data = '0;
		for (int k = 0; k < 9; k++) begin
			push_data[k*CW +: CW] = adj_s7[k];
		end
		push_data[9*CW +: DW]  = dmag_s7;
		push_data[9*CW + DW]   = dneg_s7;
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(QD))
		else $error("front occupancy beyond queue depth");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (occ_q != '0))
		else $error("back took an item the front never sent");

endmodule

@@ rtl/mi3_div.sv @@
`timescale 1ns / 1ps

module mi3_div #(
	parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH,
	parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [2*ELEM_WIDTH-1:0]       mag,
	input  logic                          neg,
	input  logic [3*ELEM_WIDTH+1:0]       d_in,
	input  logic [3*ELEM_WIDTH+1:0]       d_pipe [ELEM_WIDTH+1],
	output logic signed [ELEM_WIDTH-1:0]  res
);

	localparam int EW = ELEM_WIDTH;
	localparam int DW = 3 * EW + 2;
	localparam int NW = 2 * EW + 2 * FRAC_BITS;
	localparam int TW = NW - EW;
	localparam int XW = (TW > DW) ? TW : DW;
	localparam logic [EW-1:0] SMAX = {1'b0, {(EW-1){1'b1}}};
	localparam logic [EW-1:0] SMIN = {1'b1, {(EW-1){1'b0}}};

	logic [NW-1:0] num;
	logic [TW-1:0] top;
	logic          ovf_in;

	logic [DW-1:0] rem_sk [EW+1];
	logic [EW-1:0] qb_sk  [EW+1];
	logic          ovf_sk [EW+1];
	logic          neg_sk [EW+1];

	logic [DW:0]   t_rem  [EW+1];
	logic          ge     [EW+1];
	logic          rnd;
	logic [EW:0]   qr;
	logic          big;

	// numerator is the cofactor magnitude scaled by 2^(2*frac); its top part must stay below d
	assign num    = {mag, {(2*FRAC_BITS){1'b0}}};
	assign top    = num[NW-1:EW];
	assign ovf_in = (XW'(top) >= XW'(d_in));

	// one restoring step per stage
	always_comb begin
		t_rem[0] = '0;
		ge[0]    = 1'b0;
		for (int j = 1; j <= EW; j++) begin
			t_rem[j] = {rem_sk[j-1], qb_sk[j-1][EW-1]};
			ge[j]    = (t_rem[j] >= {1'b0, d_pipe[j-1]});
		end
	end

	// round half away from zero, then saturate
	assign rnd = ({rem_sk[EW], 1'b0} >= {1'b0, d_pipe[EW]});
	assign qr  = {1'b0, qb_sk[EW]} + (EW+1)'(rnd);
	assign big = ovf_sk[EW] || (qr >= ((EW+1)'(1) << (EW - 1)));

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sk[0] <= DW'(top);
			qb_sk[0]  <= num[EW-1:0];
			ovf_sk[0] <= ovf_in;
			neg_sk[0] <= neg;
			for (int j = 1; j <= EW; j++) begin
				rem_sk[j] <= ge[j] ? DW'(t_rem[j] - {1'b0, d_pipe[j-1]}) : t_rem[j][DW-1:0];
				qb_sk[j]  <= {qb_sk[j-1][EW-2:0], ge[j]};
				ovf_sk[j] <= ovf_sk[j-1];
				neg_sk[j] <= neg_sk[j-1];
			end
			if (big) begin
				res <= neg_sk[EW] ? SMIN : SMAX;
			end else begin
				res <= neg_sk[EW] ? -qr[EW-1:0] : qr[EW-1:0];
			end
		end
	end

endmodule

@@ rtl/mi3_back.sv @@
`timescale 1ns / 1ps

module mi3_back #(
	parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH,
	parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_empty,
	input  logic [9*2*ELEM_WIDTH+3*ELEM_WIDTH+2:0] q_data,
	output logic                                   pop,
	input  logic [mi3_pkg::THR_WIDTH-1:0]          thr,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output mi3_pkg::mi3_out_t                      out_data
);

	localparam int EW   = ELEM_WIDTH;
	localparam int CW   = 2 * EW;
	localparam int DW   = 3 * EW + 2;
	localparam int NS   = EW + 2;
	localparam int FW   = mi3_pkg::FIELD_WIDTH;
	localparam int TH   = mi3_pkg::THR_WIDTH;
	localparam int MW   = (DW > TH) ? DW : TH;
	localparam logic [EW-1:0] SMAX = {1'b0, {(EW-1){1'b1}}};
	localparam logic [EW-1:0] SMIN = {1'b1, {(EW-1){1'b0}}};

	logic                 adv;

	logic                 vld_s1;
	logic signed [CW-1:0] adj_s1 [9];
	logic [DW-1:0]        dmag_s1;
	logic                 dneg_s1;

	logic [NS-1:0]        vld_sk;
	logic                 sing_sk [NS];
	logic [EW-1:0]        detf_sk [NS];
	logic [DW-1:0]        dmag_sk [EW+1];

	logic                 sing;
	logic [DW-1:0]        dq;
	logic [EW-1:0]        detf;
	logic [CW-1:0]        mag [9];
	logic                 lneg [9];
	logic signed [EW-1:0] res [9];

	// whole back moves together unless the output slot is held
	assign adv = !(vld_sk[NS-1] && out_stall);
	assign pop = adv && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_sk <= '0;
		end else if (adv) begin
			vld_s1 <= !q_empty;
			vld_sk <= {vld_sk[NS-2:0], vld_s1};
		end
	end

	// singular check and determinant field
	always_comb begin
		sing = (dmag_s1 == '0) || (MW'(dmag_s1) < MW'(thr));
		dq   = (dmag_s1 >> (2 * FRAC_BITS)) + DW'(dmag_s1[2*FRAC_BITS-1]);
		if (dq >= (DW'(1) << (EW - 1))) begin
			detf = dneg_s1 ? SMIN : SMAX;
		end else begin
			detf = dneg_s1 ? -dq[EW-1:0] : dq[EW-1:0];
		end
		for (int k = 0; k < 9; k++) begin
			mag[k]  = adj_s1[k][CW-1] ? CW'(-adj_s1[k]) : CW'(adj_s1[k]);
			lneg[k] = adj_s1[k][CW-1] ^ dneg_s1;
		end
	end

	// entry stage and per-item sideband
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) begin
				adj_s1[k] <= q_data[k*CW +: CW];
			end
			dmag_s1 <= q_data[9*CW +: DW];
			dneg_s1 <= q_data[9*CW + DW];

			sing_sk[0] <= sing;
			detf_sk[0] <= detf;
			dmag_sk[0] <= dmag_s1;
			for (int k = 1; k < NS; k++) begin
				sing_sk[k] <= sing_sk[k-1];
				detf_sk[k] <= detf_sk[k-1];
			end
			for (int k = 1; k <= EW; k++) begin
				dmag_sk[k] <= dmag_sk[k-1];
			end
		end
	end

	// one divider lane per inverse element
	for (genvar k = 0; k < 9; k++) begin : g_lane
		mi3_div #(
			.ELEM_WIDTH (ELEM_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_div (
			.clk    (clk),
			.en     (adv),
			.mag    (mag[k]),
			.neg    (lneg[k]),
			.d_in   (dmag_s1),
			.d_pipe (dmag_sk),
			.res    (res[k])
		);
	end

	// result
	assign out_valid = vld_sk[NS-1];
	always_comb begin
		out_data             = '0;
		out_data.inv_r0c0    = sing_sk[NS-1] ? '0 : FW'(res[0]);
		out_data.inv_r0c1    = sing_sk[NS-1] ? '0 : FW'(res[1]);
		out_data.inv_r0c2    = sing_sk[NS-1] ? '0 : FW'(res[2]);
		out_data.inv_r1c0    = sing_sk[NS-1] ? '0 : FW'(res[3]);
		out_data.inv_r1c1    = sing_sk[NS-1] ? '0 : FW'(res[4]);
		out_data.inv_r1c2    = sing_sk[NS-1] ? '0 : FW'(res[5]);
		out_data.inv_r2c0    = sing_sk[NS-1] ? '0 : FW'(res[6]);
		out_data.inv_r2c1    = sing_sk[NS-1] ? '0 : FW'(res[7]);
		out_data.inv_r2c2    = sing_sk[NS-1] ? '0 : FW'(res[8]);
		out_data.determinant = FW'(signed'(detf_sk[NS-1]));
		out_data.invertible  = !sing_sk[NS-1];
	end

	a_pop_only_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (vld_s1 || $past(out_stall)) || vld_s1)
		else $error("popped entry lost before entry stage");

endmodule

@@ rtl/matrix_inverse_3x3.sv @@
`timescale 1ns / 1ps

// 3x3 fixed-point matrix inverse by adjugate and one division per element.
// in channel: in_valid / in_stall / in_data, one matrix per transfer.
// out channel: out_valid / out_stall / out_data, one result per matrix, in order.
// cfg channel: cfg_valid / cfg_ready / cfg_data writes the singular threshold;
// cfg_ready is always high, write only while no matrix is in flight.
// Throughput: one matrix per cycle while the receiver takes results.
// Path from input transfer to output transfer: a 7-stage cofactor and
// determinant front, one queue slot, then the entry stage, an operand load
// stage, ELEM_WIDTH restoring-division stages and a round/saturate stage in
// each of nine parallel divider lanes.
// When out_stall is high while a result is shown, the whole back end holds,
// the output stays put and the front keeps filling the queue; in_stall rises
// once front plus queue hold QUEUE_DEPTH matrices.
// Reset clears all valid state and loads the threshold reset value; no
// results are pending after reset.
module matrix_inverse_3x3 #(
	parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH,
	parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  mi3_pkg::mi3_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mi3_pkg::mi3_out_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mi3_pkg::THR_WIDTH-1:0] cfg_data
);

	localparam int QW = 9 * 2 * ELEM_WIDTH + 3 * ELEM_WIDTH + 3;

	logic [mi3_pkg::THR_WIDTH-1:0] thr_q;
	logic                          push;
	logic                          pop;
	logic                          q_empty;
	logic [QW-1:0]                 push_data;
	logic [QW-1:0]                 q_data;

	// threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mi3_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	mi3_front #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.pop       (pop),
		.push      (push),
		.push_data (push_data)
	);

	mi3_queue #(
		.WIDTH (QW),
		.DEPTH (mi3_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	mi3_back #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.pop       (pop),
		.thr       (thr_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
